// ----- rtl/gf2_64_ghash_multiply_assert.svh -----
// Assertion macros for the GF(2^64) GHASH multiplier port checker.
`ifndef GF2_64_GHASH_MULTIPLY_ASSERT_SVH
`define GF2_64_GHASH_MULTIPLY_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define GFM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("GHASH multiplier assertion failed");

// Next-cycle implication.
`define GFM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("GHASH multiplier assertion failed");

// Delayed implication.
`define GFM_ASSERT_DLY2(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("GHASH multiplier assertion failed");

`endif

// ----- rtl/gfm_pkg.sv -----
// Types, constants and a helper function for the GF(2^64) GHASH multiplier.
package gfm_pkg;

    localparam int WORD_W    = 64;
    localparam int PROD_W    = 2 * WORD_W - 1;
    localparam int POLY_LO_W = 5;
    // Low terms of the field polynomial x^64 + x^4 + x^3 + x + 1.
    localparam logic [POLY_LO_W-1:0] POLY_LOW = 5'b11011;
    localparam int HI_W      = PROD_W - WORD_W;
    localparam int FOLD_W    = HI_W + POLY_LO_W - 1;
    localparam int OVF_W     = FOLD_W - WORD_W;
    localparam int FOLD2_W   = OVF_W + POLY_LO_W - 1;

    // Configuration register index, taken from paddr[3].
    localparam logic REG_HASH_KEY = 1'b0;
    localparam int   ADDR_W       = 4;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [PROD_W-1:0] clprod_t;

    // The reflected convention puts x^0 in bit 63, so a plain bit reversal
    // turns a packed word into an ordinary polynomial and back.
    function automatic word_t bit_rev(input word_t v);
        word_t r;
        for (int i = 0; i < WORD_W; i++) begin
            r[i] = v[WORD_W-1-i];
        end
        return r;
    endfunction

endpackage

// ----- rtl/gfm_clmul.sv -----
// Carry-less 64 x 64 polynomial product over GF(2).
module gfm_clmul
    import gfm_pkg::*;
(
    input  word_t   a,
    input  word_t   b,
    output clprod_t c
);

    for (genvar gi = 0; gi < PROD_W; gi++) begin : g_col
        logic [WORD_W-1:0] col;
        for (genvar gj = 0; gj < WORD_W; gj++) begin : g_term
            if ((gi - gj >= 0) && (gi - gj < WORD_W)) begin : g_and
                assign col[gj] = a[gj] & b[gi-gj];
            end
            else begin : g_zero
                assign col[gj] = 1'b0;
            end
        end
        assign c[gi] = ^col;
    end

endmodule

// ----- rtl/gfm_reduce.sv -----
// Reduction of a 127-bit carry-less product modulo x^64 + x^4 + x^3 + x + 1.
module gfm_reduce
    import gfm_pkg::*;
(
    input  clprod_t c,
    output word_t   r
);

    logic [HI_W-1:0]    hi;
    logic [FOLD_W-1:0]  fold1;
    logic [OVF_W-1:0]   ovf;
    logic [FOLD2_W-1:0] fold2;

    assign hi  = c[PROD_W-1:WORD_W];
    assign ovf = fold1[FOLD_W-1:WORD_W];

    // x^64 folds back as the low terms of the polynomial; the first fold
    // can spill a few bits past x^63, which a second fold settles.
    always_comb
    begin
        fold1 = '0;
        fold2 = '0;
        for (int m = 0; m < POLY_LO_W; m++) begin
            if (POLY_LOW[m]) begin
                fold1 = fold1 ^ ({{(FOLD_W-HI_W){1'b0}}, hi} << m);
                fold2 = fold2 ^ ({{(FOLD2_W-OVF_W){1'b0}}, ovf} << m);
            end
        end
    end

    assign r = c[WORD_W-1:0] ^ fold1[WORD_W-1:0]
             ^ {{(WORD_W-FOLD2_W){1'b0}}, fold2};

endmodule

// ----- rtl/gf2_64_ghash_multiply.sv -----
// Top level of the GF(2^64) GHASH multiplier: register port and pipeline.
// A block passes the input register and then the result register on its way to out_valid.
// Throughput: one block per cycle while the result side is not stalled; the input register feeds a single
// AND/XOR network (carry-less product plus fold) that ends in the result register.
// Reset: rst_n clears both valid flags and sets hash_key to zero; data
// registers are not reset.
module gf2_64_ghash_multiply
    import gfm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Input channel.
    input  logic              in_valid,
    output logic              in_stall,
    input  word_t             block_in,
    // Result channel.
    output logic              out_valid,
    input  logic              out_stall,
    output word_t             product,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  word_t             pwdata,
    output word_t             prdata,
    output logic              pready
);

    // Pipeline registers. The input stage holds the block, the output stage
    // holds the finished product.
    logic  in_valid_reg, in_valid_next;
    word_t block_reg;
    logic  out_valid_reg, out_valid_next;
    word_t product_reg;
    word_t hash_key_reg, hash_key_next;

    logic    out_free;
    logic    in_take;
    logic    cfg_write;
    clprod_t clprod;
    word_t   reduced;

    // The output register can load whenever it is empty or its current
    // result is being transferred out this cycle.
    assign out_free  = !out_valid_reg || !out_stall;
    // The input register takes a new block unless it is full and cannot
    // pass its block on, so a block can enter while a result still waits.
    assign in_stall  = in_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign product   = product_reg;

    // Register writes complete on the access phase; pready never waits.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        hash_key_next = hash_key_reg;
        if (cfg_write) begin
            unique case (paddr[ADDR_W-1])
                REG_HASH_KEY: hash_key_next = pwdata;
                default:      hash_key_next = hash_key_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[ADDR_W-1])
            REG_HASH_KEY: prdata = hash_key_reg;
            default:      prdata = '0;
        endcase
    end

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = in_valid_reg;
            in_valid_next  = in_valid;
        end
        else if (!in_valid_reg) begin
            in_valid_next = in_valid;
        end
    end

    // Both operands are bit-reversed into ordinary polynomial order, the
    // product is formed and folded, and the result is reversed back into
    // the reflected big-endian packing.
    gfm_clmul u_clmul (
        .a (bit_rev(block_reg)),
        .b (bit_rev(hash_key_reg)),
        .c (clprod)
    );

    gfm_reduce u_reduce (
        .c (clprod),
        .r (reduced)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hash_key_reg  <= '0;
        end
        else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            hash_key_reg  <= hash_key_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            block_reg <= block_in;
        end
        if (out_free && in_valid_reg) begin
            product_reg <= bit_rev(reduced);
        end
    end

endmodule

// ----- rtl/gf2_64_ghash_multiply_chk.sv -----
// Port-level assertions for the GF(2^64) GHASH multiplier, bound to the top level.
`include "gf2_64_ghash_multiply_assert.svh"

module gf2_64_ghash_multiply_chk
    import gfm_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_stall,
    input logic  out_valid,
    input logic  out_stall,
    input word_t product
);

    // A stalled result stays offered and does not change.
    `GFM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(product))
    // The input side only stalls when a result is waiting and blocked.
    `GFM_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)
    // After every accepted block, out_valid is asserted once the pipeline registers have been passed.
    `GFM_ASSERT_DLY2(a_latency, in_valid && !in_stall, out_valid)
    // With no result offered and no block offered, the input is then not stalled.
    `GFM_ASSERT_NEXT(a_drain, !out_valid && !in_valid, !in_stall)

endmodule

bind gf2_64_ghash_multiply gf2_64_ghash_multiply_chk u_chk (.*);

// ----- test/gf2_64_ghash_multiply_checker.sv -----
// Checker for the GHASH multiplier: watches both channels and the register port, predicts products.
module gf2_64_ghash_multiply_checker
    import gfm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  word_t             block_in,
    input  logic              out_valid,
    input  logic              out_stall,
    input  word_t             product,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  word_t             pwdata,
    input  word_t             prdata,
    input  logic              pready,
    output int unsigned       mismatches,
    output int unsigned       outstanding,
    output int unsigned       products_checked
);

    // Multiplying by x shifts right; a set bit shifted out folds this into the top byte.
    localparam word_t REDUCE_TOP = {8'hD8, 56'h0};

    typedef struct packed {
        word_t block;
        word_t product;
    } pending_product_t;

    pending_product_t product_fifo[$];
    word_t            key_shadow;

    // Horner evaluation over the block bits, bit 0 first.
    function automatic word_t gf64_reflected_mul(input word_t block, input word_t key);
        word_t acc;
        acc = '0;
        for (int k = 0; k < WORD_W; k++) begin
            acc = {1'b0, acc[WORD_W-1:1]} ^ (acc[0] ? REDUCE_TOP : '0);
            if (block[k]) begin
                acc = acc ^ key;
            end
        end
        return acc;
    endfunction

    task automatic report(input string what, input word_t blk, input word_t exp_v,
                          input word_t act_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch (%s): block %h expected %h got %h", what, blk, exp_v, act_v);
        end
    endtask

    initial begin
        mismatches       = 0;
        outstanding      = 0;
        products_checked = 0;
        key_shadow       = '0;
    end

    always @(posedge clk or negedge rst_n) begin
        pending_product_t head;
        if (!rst_n) begin
            key_shadow = '0;
            product_fifo.delete();
        end else begin
            // Register port: only the hash key decodes; the upper index is ignored.
            if (psel && penable && pready) begin
                if (pwrite && paddr[3] == REG_HASH_KEY) begin
                    key_shadow = pwdata;
                end else if (!pwrite && paddr[3] == REG_HASH_KEY && prdata !== key_shadow) begin
                    report("key readback", '0, key_shadow, prdata);
                end
            end
            if (in_valid && !in_stall) begin
                product_fifo.push_back('{block: block_in,
                                         product: gf64_reflected_mul(block_in, key_shadow)});
            end
            if (out_valid && !out_stall) begin
                products_checked++;
                if (product_fifo.size() == 0) begin
                    report("unexpected result", '0, '0, product);
                end else begin
                    head = product_fifo.pop_front();
                    if (product !== head.product) begin
                        report("product", head.block, head.product, product);
                    end
                end
            end
        end
        outstanding = product_fifo.size();
    end

endmodule

// ----- test/gf2_64_ghash_multiply_tb.sv -----
// Testbench top for the GHASH multiplier: clock, reset, stimulus and verdict.
module gf2_64_ghash_multiply_tb;
    import gfm_pkg::*;

    // Byte addresses on the register port: the hash key, and the unused slot above it.
    localparam logic [ADDR_W-1:0] ADDR_HASH_KEY = {REG_HASH_KEY, 3'b000};
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = {~REG_HASH_KEY, 3'b000};
    // Generous cap, allowing for the longest send gap and stall burst on every item.
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned NUM_PHASES  = 8;
    localparam int unsigned PHASE_ITEMS = 100;
    localparam int unsigned CALM_ITEMS  = 150;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    word_t             block_in;
    logic              out_valid;
    logic              out_stall;
    word_t             product;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    word_t             pwdata;
    word_t             prdata;
    logic              pready;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned products_checked;
    int unsigned key_writes;
    int unsigned cycle_count;
    // Idle weight: out of 16 for a send gap, out of 32 for an output stall burst;
    // zero means no idling at all.
    int unsigned idle_odds;

    gf2_64_ghash_multiply i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .block_in  (block_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .product   (product),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    gf2_64_ghash_multiply_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .block_in         (block_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .product          (product),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .products_checked (products_checked)
    );

    // Free-running clock with a period of 4.
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Random 64-bit value with a bias toward sparse and byte-structured patterns,
    // since those stress the reduction fold and the byte ordering.
    function automatic word_t pick_word();
        word_t v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = word_t'(1) << $urandom_range(0, WORD_W - 1);
            1: v = ~(word_t'(1) << $urandom_range(0, WORD_W - 1));
            2: begin
                for (int b = 0; b < 8; b++) begin
                    case ($urandom_range(0, 2))
                        0: v[8*b +: 8] = 8'h00;
                        1: v[8*b +: 8] = 8'hFF;
                        default: v[8*b +: 8] = 8'($urandom);
                    endcase
                end
            end
            3: v = v & {$urandom, $urandom} & {$urandom, $urandom};
            default: ;
        endcase
        return v;
    endfunction

    // The receiver stalls in random bursts while idling is allowed.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (idle_odds != 0 && $urandom_range(0, 31) < idle_odds) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // One input transfer. The payload is held until the edge at which stall is low.
    // A send gap, when one is drawn, comes first so that valid is lowered only then.
    task automatic send_block(input word_t value);
        if (idle_odds != 0 && $urandom_range(0, 15) < idle_odds) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        block_in <= value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Lets every outstanding product come back and then lets the two-stage pipeline settle,
    // so the key register can be touched while the block is idle.
    // The first edge lets the checker count the block taken at the edge just passed.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Setup and access cycles of one register port transfer.
    task automatic reg_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input word_t data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (wr && addr == ADDR_HASH_KEY) begin
            key_writes++;
        end
    endtask

    // Writes the key and reads it back; the checker compares the readback.
    task automatic load_key(input word_t key);
        drain();
        reg_access(1'b1, ADDR_HASH_KEY, key);
        reg_access(1'b0, ADDR_HASH_KEY, '0);
    endtask

    initial
    begin
        word_t phase_key;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        block_in   = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        key_writes = 0;
        idle_odds  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The key is still at its reset value of zero, so every
        // product must be zero whatever the block.
        send_block('1);
        send_block({$urandom, $urandom});

        // A zero block gives zero; a lone x^0 (bit 63) returns the key itself; a lone
        // x^63 (bit 0) and the all-ones block exercise the full reduction chain.
        load_key({$urandom, $urandom});
        send_block('0);
        send_block({1'b1, 63'h0});
        send_block(64'h1);
        send_block('1);

        // The key x^0 is the multiplicative identity, so products equal blocks.
        load_key({1'b1, 63'h0});
        send_block({$urandom, $urandom});
        send_block('1);

        // All-ones key against the extremes of the block.
        load_key('1);
        send_block('1);
        send_block(64'h1);
        send_block('0);

        // Key x^63: x^63 * x^63 = x^126 needs the most folding.
        load_key(64'h1);
        send_block(64'h1);
        send_block('1);
        send_block({1'b1, 63'h0});

        // A write to the index beyond the register list must leave the key unchanged.
        load_key({$urandom, $urandom});
        drain();
        reg_access(1'b1, ADDR_UNMAPPED, '1);
        reg_access(1'b0, ADDR_UNMAPPED, '0);
        send_block({$urandom, $urandom});
        send_block('1);

        // A zero key written explicitly, after it was nonzero.
        load_key('0);
        send_block({$urandom, $urandom});
        send_block('1);

        // Random part: one key per phase, from random to the extremes, with idling
        // that changes from phase to phase and is sometimes off for a whole phase.
        for (int unsigned p = 0; p < NUM_PHASES; p++) begin
            case (p)
                2: phase_key = '1;
                4: phase_key = {1'b1, 63'h0};
                6: phase_key = 64'h1;
                default: phase_key = pick_word();
            endcase
            load_key(phase_key);
            idle_odds = (p % 3 == 2) ? 0 : $urandom_range(2, 6);
            for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
                send_block(pick_word());
            end
        end

        // Last stretch at full rate: no gaps on the input and no new stall bursts on the output.
        // Idling is switched off before the drain, so that no new stall burst starts in it.
        idle_odds = 0;
        load_key({$urandom, $urandom});
        for (int unsigned n = 0; n < CALM_ITEMS; n++) begin
            send_block(pick_word());
        end

        drain();
        repeat (8) @(posedge clk);

        $display("Checked %0d products across %0d hash key writes, random and extreme keys,",
                 products_checked, key_writes);
        $display("with idle bursts on both channels and a final full-rate stretch.");
        if (outstanding != 0) begin
            $display("%0d expected products never arrived", outstanding);
        end
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/gfm_pkg.sv
rtl/gfm_clmul.sv
rtl/gfm_reduce.sv
rtl/gf2_64_ghash_multiply.sv
rtl/gf2_64_ghash_multiply_chk.sv
test/gf2_64_ghash_multiply_checker.sv
test/gf2_64_ghash_multiply_tb.sv
